// ===== design/ocpc_pkg.sv =====
// shared types, constants and drive function for the output channel pulse controller
package ocpc_pkg;

   localparam int CHANNELS = 8;
   localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   localparam logic       CMD_UPDATE = 1'b0;
   localparam logic       CMD_TICK   = 1'b1;

   localparam logic [2:0] MODE_DIGITAL = 3'd0;
   localparam logic [2:0] MODE_ANALOG  = 3'd1;
   localparam logic [2:0] MODE_FADE    = 3'd2;
   localparam logic [2:0] MODE_PULSE   = 3'd3;
   localparam logic [2:0] MODE_OTHER   = 3'd4;

   localparam logic [7:0]  FULL_ON   = 8'd255;
   localparam logic [63:0] IDS_RESET = 64'h0706050403020100;

   typedef struct packed {
      logic       cmd;
      logic [7:0] target_id;
      logic [2:0] mode_sel;
      logic [7:0] level;
      logic [7:0] pulse_count;
   } req_word_type;

   typedef struct packed {
      logic [63:0] drive_levels;
      logic        matched;
      logic        pulses_running;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [7:0] level;
      logic [7:0] count;
      logic [7:0] drive;
   } chan_type;

   typedef struct packed {
      logic hit;
      logic running;
   } unit_flags_type;

   typedef enum logic [1:0] {
      SEQ_IDLE,
      SEQ_SCAN,
      SEQ_DONE
   } seq_state_type;

   function automatic logic [7:0] recompute_drive(input logic [2:0] mode,
                                                  input logic [7:0] level,
                                                  input logic [7:0] count,
                                                  input logic [7:0] drive);
      logic [7:0] result;
      result = drive;
      if (mode == MODE_DIGITAL) begin
         if (level == FULL_ON) result = FULL_ON;
         else if (level == 8'd0) result = 8'd0;
      end else if (mode == MODE_ANALOG) begin
         result = level;
      end else if (mode == MODE_PULSE) begin
         result = (count != 8'd0) ? level : 8'd0;
      end
      return result;
   endfunction

endpackage

// ===== design/ocpc_chan_unit.sv =====
// shared per-channel update and countdown unit
module ocpc_chan_unit (
   input  ocpc_pkg::req_word_type   req,
   input  logic [7:0]               chan_id,
   input  logic                     found,
   input  ocpc_pkg::chan_type       chan_cur,
   output ocpc_pkg::chan_type       chan_nxt,
   output ocpc_pkg::unit_flags_type flags
);
   import ocpc_pkg::*;

   logic [2:0] mode_eff;
   logic [7:0] count_dec;

   assign mode_eff  = (req.mode_sel > MODE_OTHER) ? MODE_OTHER : req.mode_sel;
   assign count_dec = chan_cur.count - 8'd1;

   always_comb begin
      chan_nxt      = chan_cur;
      flags.hit     = 1'b0;
      flags.running = 1'b0;
      unique case (req.cmd)
         CMD_UPDATE: begin
            if (!found && (chan_id == req.target_id)) begin
               flags.hit     = 1'b1;
               chan_nxt.mode = mode_eff;
               if ((chan_cur.level != req.level) || (chan_cur.count != req.pulse_count)) begin
                  chan_nxt.level = req.level;
                  chan_nxt.count = req.pulse_count;
                  chan_nxt.drive = recompute_drive(mode_eff, req.level, req.pulse_count,
                                                   chan_cur.drive);
               end
            end
         end
         CMD_TICK: begin
            if ((chan_cur.mode == MODE_PULSE) && (chan_cur.count != 8'd0)) begin
               flags.running  = 1'b1;
               chan_nxt.count = count_dec;
               if (count_dec == 8'd0) begin
                  chan_nxt.drive = recompute_drive(chan_cur.mode, chan_cur.level, count_dec,
                                                   chan_cur.drive);
               end
            end
         end
         default: begin
            chan_nxt = chan_cur;
         end
      endcase
   end

endmodule

// ===== design/output_channel_pulse_controller.sv =====
// top level: sequencer walking the channel unit over all channels
// sequence: start accepted, then the scan visits each channel in turn, then a one-cycle result strobe
// a new word is taken only once the scan of all channels is through; set by the single shared channel unit
// a new start is taken during the result cycle; the receiver cannot stall
// synchronous active-high reset restores ids, modes (other), levels, counts and drives
module output_channel_pulse_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  ocpc_pkg::req_word_type req_data,
   output logic                   rsp_valid,
   output ocpc_pkg::rsp_word_type rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [63:0]            csr_wdata
);
   import ocpc_pkg::*;

   seq_state_type         state_ff, state_in;
   req_word_type          req_ff;
   logic [CH_IDX_W-1:0]   idx_ff;
   logic                  found_ff;
   logic                  running_ff;
   logic [63:0]           ids_ff;
   chan_type              chan_ff [CHANNELS];
   chan_type              chan_cur, chan_nxt;
   unit_flags_type        flags;
   logic [7:0]            chan_id;
   logic                  accept;
   logic                  last;
   logic [63:0]           drives_packed;

   assign accept   = start && !busy;
   assign last     = (idx_ff == CH_IDX_W'(CHANNELS - 1));
   assign chan_cur = chan_ff[idx_ff];
   assign chan_id  = ids_ff[{idx_ff, 3'b000} +: 8];

   ocpc_chan_unit u_chan_unit (
      .req      (req_ff),
      .chan_id  (chan_id),
      .found    (found_ff),
      .chan_cur (chan_cur),
      .chan_nxt (chan_nxt),
      .flags    (flags)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: if (accept) state_in = SEQ_SCAN;
         SEQ_SCAN: if (last) state_in = SEQ_DONE;
         SEQ_DONE: state_in = accept ? SEQ_SCAN : SEQ_IDLE;
         default:  state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy      = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         SEQ_IDLE: busy = 1'b0;
         SEQ_SCAN: busy = 1'b1;
         SEQ_DONE: rsp_valid = 1'b1;
         default:  busy = 1'b0;
      endcase
   end

   assign csr_ready = !busy;

   always_comb begin
      drives_packed = '0;
      for (int c = 0; c < CHANNELS; c++) begin
         drives_packed[c*8 +: 8] = chan_ff[c].drive;
      end
   end

   assign rsp_data.drive_levels   = drives_packed;
   assign rsp_data.matched        = found_ff;
   assign rsp_data.pulses_running = running_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= SEQ_IDLE;
         idx_ff     <= '0;
         found_ff   <= 1'b0;
         running_ff <= 1'b0;
         ids_ff     <= IDS_RESET;
         for (int c = 0; c < CHANNELS; c++) begin
            chan_ff[c] <= '{mode: MODE_OTHER, level: 8'd0, count: 8'd0, drive: 8'd0};
         end
      end else begin
         state_ff <= state_in;
         if (csr_valid && csr_ready) ids_ff <= csr_wdata;
         if (accept) begin
            idx_ff     <= '0;
            found_ff   <= 1'b0;
            running_ff <= 1'b0;
         end else if (state_ff == SEQ_SCAN) begin
            chan_ff[idx_ff] <= chan_nxt;
            found_ff        <= found_ff | flags.hit;
            running_ff      <= running_ff | flags.running;
            if (!last) idx_ff <= idx_ff + CH_IDX_W'(1);
         end
      end
   end

   // request word, no reset needed
   always_ff @(posedge clock) begin
      if (accept) req_ff <= req_data;
   end

endmodule
